// File: design/iapm_pkg.sv
// Shared types, constants and the level-scale helper for the peak meter.
package iapm_pkg;

	localparam int MAX_CHANNELS = 8;
	localparam int CH_LIMIT_I = (MAX_CHANNELS < 8) ? MAX_CHANNELS : 8;
	localparam logic [3:0] CH_LIMIT = 4'(CH_LIMIT_I);
	localparam logic [3:0] COUNT_RESET = 4'd2;
	localparam int LOG_STEPS = 24;
	localparam logic [14:0] FULL_SCALE = 15'h7fff;
	localparam logic [22:0] DB_SCALE_Q16 = 23'd6313057;
	localparam logic signed [11:0] SILENCE_DB = -12'sd1600;

	function automatic logic [27:0] log2_q24(input logic [14:0] p);
		logic [63:0] x;
		logic [23:0] frac;
		logic [3:0] n;
		n = 4'd0;
		frac = 24'd0;
		for (int i = 1; i < 15; i++) begin
			if (p[i]) begin
				n = 4'(i);
			end
		end
		x = 64'(p) << (6'd30 - 6'(n));
		for (int i = 0; i < LOG_STEPS; i++) begin
			x = (x * x) >> 30;
			frac = frac << 1;
			if (x >= (64'd1 << 31)) begin
				x = x >> 1;
				frac[0] = 1'b1;
			end
		end
		return {n, frac};
	endfunction

	localparam logic [27:0] LOG2_FS = log2_q24(FULL_SCALE);

	typedef struct packed {
		logic       accept;
		logic       clear;
		logic       load;
		logic       iter;
		logic       diff;
		logic       scale;
		logic       put;
		logic [2:0] chan;
		logic       last;
	} iapm_cmd_t;

	typedef struct packed {
		logic [3:0] count;
		logic       out_free;
	} iapm_stat_t;

endpackage

// File: design/iapm_ctl.sv
// Sequencer that gathers samples and steps the level computation per channel.
module iapm_ctl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                frame_end,
	input  iapm_pkg::iapm_stat_t stat,
	output iapm_pkg::iapm_cmd_t  cmd,
	output logic                busy
);
	import iapm_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOAD  = 3'd1;
	localparam logic [2:0] ST_ITER  = 3'd2;
	localparam logic [2:0] ST_DIFF  = 3'd3;
	localparam logic [2:0] ST_SCALE = 3'd4;
	localparam logic [2:0] ST_PUT   = 3'd5;
	localparam logic [4:0] ITER_LAST = 5'(LOG_STEPS - 1);

	logic [2:0] state_q, state_d;
	logic [2:0] chan_q, chan_d;
	logic [4:0] step_q, step_d;
	logic       last;

	assign last = ({1'b0, chan_q} + 4'd1) == stat.count;
	assign busy = state_q != ST_IDLE;

	always_comb begin
		state_d = state_q;
		chan_d = chan_q;
		step_d = step_q;
		cmd = '0;
		cmd.chan = chan_q;
		cmd.last = last;
		case (state_q)
			ST_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid && frame_end) begin
					chan_d = 3'd0;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				step_d = 5'd0;
				state_d = ST_ITER;
			end
			ST_ITER: begin
				cmd.iter = 1'b1;
				step_d = step_q + 5'd1;
				if (step_q == ITER_LAST) begin
					state_d = ST_DIFF;
				end
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d = ST_PUT;
			end
			ST_PUT: begin
				if (stat.out_free) begin
					cmd.put = 1'b1;
					if (last) begin
						cmd.clear = 1'b1;
						state_d = ST_IDLE;
					end else begin
						chan_d = chan_q + 3'd1;
						state_d = ST_LOAD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chan_q <= 3'd0;
			step_q <= 5'd0;
		end else begin
			state_q <= state_d;
			chan_q <= chan_d;
			step_q <= step_d;
		end
	end

endmodule

// File: design/iapm_dp.sv
// Peak registers, channel rotation, log2 squaring unit, scaling and output register.
module iapm_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  iapm_pkg::iapm_cmd_t  cmd,
	output iapm_pkg::iapm_stat_t stat,
	input  logic                 cfg_valid,
	input  logic [3:0]           cfg_data,
	input  logic signed [15:0]   sample_value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [2:0]           channel_index,
	output logic signed [11:0]   level_db,
	output logic                 last_channel
);
	import iapm_pkg::*;

	logic [3:0]  count_q;
	logic [3:0]  count;
	logic [2:0]  pos_q;
	logic [2:0]  pos_in;
	logic [3:0]  pos_next;
	logic [14:0] peak_q [8];
	logic [15:0] raw_mag;
	logic [14:0] mag;
	logic [14:0] sel_peak;
	logic [3:0]  msb;
	logic [30:0] x_q;
	logic [61:0] sq;
	logic [23:0] frac_q;
	logic [3:0]  n_q;
	logic        zero_q;
	logic [27:0] m_q;
	logic [50:0] prod_q;
	logic [51:0] rounded;
	logic [11:0] db_mag;
	logic        out_valid_q;

	always_comb begin
		if (count_q == 4'd0) begin
			count = 4'd1;
		end else if (count_q > CH_LIMIT) begin
			count = CH_LIMIT;
		end else begin
			count = count_q;
		end
	end

	assign stat.count = count;
	assign stat.out_free = !out_valid_q || !out_stall;

	assign raw_mag = sample_value[15] ? 16'(-sample_value) : 16'(sample_value);
	assign mag = (raw_mag > 16'(FULL_SCALE)) ? FULL_SCALE : raw_mag[14:0];

	assign pos_in = ({1'b0, pos_q} >= count) ? 3'd0 : pos_q;
	assign pos_next = ({1'b0, pos_in} + 4'd1 >= count) ? 4'd0 : {1'b0, pos_in} + 4'd1;

	assign sel_peak = peak_q[cmd.chan];

	always_comb begin
		msb = 4'd0;
		for (int i = 1; i < 15; i++) begin
			if (sel_peak[i]) begin
				msb = 4'(i);
			end
		end
	end

	assign sq = 62'(x_q) * 62'(x_q);
	assign rounded = {1'b0, prod_q} + (52'd1 << 39);
	assign db_mag = rounded[51:40];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
			pos_q <= 3'd0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				peak_q[i] <= 15'd0;
			end
		end else begin
			if (cfg_valid) begin
				count_q <= cfg_data;
			end
			if (cmd.clear) begin
				pos_q <= 3'd0;
				for (int i = 0; i < 8; i++) begin
					peak_q[i] <= 15'd0;
				end
			end else if (cmd.accept) begin
				pos_q <= pos_next[2:0];
				for (int i = 0; i < 8; i++) begin
					if (pos_in == 3'(i) && mag > peak_q[i]) begin
						peak_q[i] <= mag;
					end
				end
			end
			if (cmd.put) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= 31'(sel_peak) << (5'd30 - 5'(msb));
			n_q <= msb;
			zero_q <= sel_peak == 15'd0;
			frac_q <= 24'd0;
		end
		if (cmd.iter) begin
			frac_q <= {frac_q[22:0], sq[61]};
			x_q <= sq[61] ? sq[61:31] : sq[60:30];
		end
		if (cmd.diff) begin
			m_q <= LOG2_FS - {n_q, frac_q};
		end
		if (cmd.scale) begin
			prod_q <= 51'(m_q) * 51'(DB_SCALE_Q16);
		end
		if (cmd.put) begin
			channel_index <= cmd.chan;
			last_channel <= cmd.last;
			level_db <= zero_q ? SILENCE_DB : $signed(12'd0 - db_mag);
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: design/interleaved_audio_peak_meter_db.sv
// Top level of the interleaved audio peak meter with levels in 1/16 dBFS.
//
// Input channel: in_valid/in_stall carry one signed sample per item plus a
// frame_end flag; channels rotate from 0 up to one below the configured count.
// Configuration: cfg_valid/cfg_ready write the 4-bit channel count; cfg_ready
// is always high. Write only while idle with all results taken.
// Output channel: out_valid/out_stall carry one level per channel, in channel
// order, with last_channel set on the final one.
// A sample without frame_end does not stall the input; samples can follow
// back to back. A sample with frame_end stalls the input while levels are
// computed: each channel goes through load, 24 squaring steps of the log2
// unit, difference, scale multiply and output write, and the input reopens
// on the cycle the last level enters the output register.
// If the receiver stalls, the sequencer holds the computed level until
// the output register frees, and the input stays stalled meanwhile; only the
// last level of a frame, once in the output register, leaves the input open.
// Reset clears all peaks and the channel position and sets the count to 2.
module interleaved_audio_peak_meter_db (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] sample_value,
	input  logic               frame_end,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         channel_index,
	output logic signed [11:0] level_db,
	output logic               last_channel,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_data
);
	import iapm_pkg::*;

	iapm_cmd_t  cmd;
	iapm_stat_t stat;
	logic       busy;

	assign cfg_ready = 1'b1;
	assign in_stall = busy;

	iapm_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.frame_end(frame_end),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	iapm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.sample_value (sample_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.channel_index(channel_index),
		.level_db     (level_db),
		.last_channel (last_channel)
	);

	a_frame_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && frame_end |=> in_stall)
		else $error("input not stalled after frame end");

	a_sample_open: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !frame_end |=> !in_stall)
		else $error("input stalled after plain sample");

	a_last_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_channel == (({1'b0, channel_index} + 4'd1) == stat.count)))
		else $error("last_channel does not match channel count");

	a_no_put_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |-> (!out_valid || !out_stall))
		else $error("level written over a held item");

endmodule

// File: sim/tb.sv
// Self-checking testbench for the interleaved audio peak meter with levels in 1/16 dBFS.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned FULL_CODE = 32767;
	localparam logic [63:0] DB_PER_LOG2_Q16 = 64'd6313057;
	localparam logic signed [11:0] QUIET_DB = -12'sd1600;
	localparam int unsigned RANDOM_ITEMS = 330;

	typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_RUNS} rx_style_t;

	typedef struct packed {
		logic signed [15:0] s;
		logic               fe;
	} sample_t;

	typedef struct packed {
		logic [2:0]         ch;
		logic signed [11:0] lvl;
		logic               last;
	} level_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [15:0] sample_value = '0;
	logic               frame_end = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [2:0]         channel_index;
	logic signed [11:0] level_db;
	logic               last_channel;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [3:0]         cfg_data = '0;

	sample_t     pend_q[$];
	level_t      level_q[$];
	logic [14:0] peak_mem [8] = '{default: '0};
	logic [2:0]  chan_pos = '0;
	logic [3:0]  chan_cnt = iapm_pkg::COUNT_RESET;

	logic        in_took = 1'b0;
	logic        out_took = 1'b0;
	logic        cfg_hit = 1'b0;
	logic        send_gaps = 1'b0;
	rx_style_t   rx_style = RX_FREE;
	logic        holdoff_go = 1'b0;
	logic        hold_used = 1'b0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned hold_left = 0;
	int unsigned run_left = 0;
	logic        run_stalled = 1'b0;
	int unsigned quiet_cycles = 0;
	int unsigned errors = 0;
	int unsigned n_samples = 0;
	int unsigned n_levels = 0;
	int unsigned n_frames = 0;
	int unsigned n_writes = 0;
	int unsigned n_held = 0;

	interleaved_audio_peak_meter_db dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.sample_value  (sample_value),
		.frame_end     (frame_end),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.channel_index (channel_index),
		.level_db      (level_db),
		.last_channel  (last_channel),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int unsigned eff_count();
		int unsigned lim;
		lim = (iapm_pkg::MAX_CHANNELS < 8) ? iapm_pkg::MAX_CHANNELS : 8;
		if (chan_cnt == 0) return 1;
		if (chan_cnt > lim) return lim;
		return chan_cnt;
	endfunction

	function automatic logic [27:0] log2_fix(input int unsigned p);
		int unsigned whole;
		int unsigned t;
		logic [63:0] x;
		logic [23:0] f;
		whole = 0;
		t = p;
		while (t > 1) begin
			t = t >> 1;
			whole++;
		end
		x = 64'(p) << (30 - whole);
		f = '0;
		repeat (24) begin
			x = (x * x) >> 30;
			f = f << 1;
			if (x >= 64'h8000_0000) begin
				x = x >> 1;
				f[0] = 1'b1;
			end
		end
		return {whole[3:0], f};
	endfunction

	task automatic absorb(input logic signed [15:0] s, input logic fe);
		int unsigned cnt;
		int unsigned pos;
		int unsigned mag;
		logic [15:0] raw;
		logic [63:0] span;
		level_t lv;
		cnt = eff_count();
		raw = s;
		mag = raw[15] ? 32'h10000 - raw : raw;
		if (mag > FULL_CODE) mag = FULL_CODE;
		pos = chan_pos;
		if (pos >= cnt) pos = 0;
		if (mag > peak_mem[pos]) peak_mem[pos] = mag[14:0];
		pos++;
		if (pos >= cnt) pos = 0;
		chan_pos = pos[2:0];
		if (fe) begin
			for (int k = 0; k < cnt; k++) begin
				lv.ch = 3'(k);
				lv.last = (k + 1 == cnt);
				if (peak_mem[k] == 0) begin
					lv.lvl = QUIET_DB;
				end else begin
					span = 64'(log2_fix(FULL_CODE)) - 64'(log2_fix(peak_mem[k]));
					span = (span * DB_PER_LOG2_Q16 + (64'd1 << 39)) >> 40;
					lv.lvl = 12'(64'd0 - span);
				end
				level_q.push_back(lv);
			end
			for (int k = 0; k < 8; k++) peak_mem[k] = '0;
			chan_pos = '0;
			n_frames++;
		end
	endtask

	always @(posedge clk) begin : monitor
		level_t want;
		in_took = arst_n && in_valid && !in_stall;
		out_took = arst_n && out_valid && !out_stall;
		cfg_hit = arst_n && cfg_valid && cfg_ready;
		if (arst_n && in_valid && in_stall) n_held++;
		if (out_took) begin
			if (level_q.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected level: expected none, got ch %0d level %0d last %0b",
					$time, channel_index, level_db, last_channel);
			end else begin
				want = level_q.pop_front();
				n_levels++;
				if (channel_index !== want.ch || level_db !== want.lvl ||
						last_channel !== want.last) begin
					errors++;
					$display("%0t ns: level mismatch: expected ch %0d level %0d last %0b, got ch %0d level %0d last %0b",
						$time, want.ch, want.lvl, want.last, channel_index, level_db, last_channel);
				end
			end
		end
		if (in_took) begin
			absorb(sample_value, frame_end);
			n_samples++;
		end
		if (cfg_hit) chan_cnt = cfg_data;
		if (in_took || out_took || cfg_hit) quiet_cycles = 0;
		else quiet_cycles++;
	end

	always @(negedge clk) begin : driver
		sample_t nx;
		logic nv;
		if (!(in_valid && !in_took)) begin
			nv = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pend_q.size() > 0) begin
				nx = pend_q.pop_front();
				sample_value <= nx.s;
				frame_end <= nx.fe;
				nv = 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else if (send_gaps) begin
					burst_left = $urandom_range(0, 15);
					gap_left = $urandom_range(1, 10);
				end
			end
			in_valid <= nv;
		end
	end

	always @(negedge clk) begin : receiver
		logic st;
		if (holdoff_go && !hold_used) begin
			hold_left = 400;
			hold_used = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			st = 1'b1;
		end else begin
			case (rx_style)
				RX_FREE: begin
					st = 1'b0;
				end
				RX_RANDOM: begin
					st = ($urandom_range(0, 2) == 0);
				end
				default: begin
					if (run_left == 0) begin
						run_stalled = !run_stalled;
						run_left = $urandom_range(1, 12);
					end
					run_left--;
					st = run_stalled;
				end
			endcase
		end
		out_stall <= st;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("%0t ns: watchdog: no traffic for %0d cycles", $time, quiet_cycles);
		$display("end of test: mismatches");
		$finish;
	end

	task automatic add(input logic signed [15:0] s, input logic fe);
		sample_t it;
		it.s = s;
		it.fe = fe;
		pend_q.push_back(it);
	endtask

	task automatic quiesce();
		do begin
			@(negedge clk);
			#1;
		end while (pend_q.size() != 0 || in_valid || level_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_count(input logic [3:0] v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(negedge clk); while (!cfg_hit);
		cfg_valid <= 1'b0;
		n_writes++;
	endtask

	task automatic queue_frame(input int unsigned len, input logic with_end);
		logic [7:0] mute;
		logic signed [15:0] s;
		int unsigned cnt;
		cnt = eff_count();
		mute = 8'($urandom & $urandom);
		for (int unsigned i = 0; i < len; i++) begin
			case ($urandom_range(0, 9))
				0: s = 16'sh8000;
				1: s = 16'sh7fff;
				2: s = 16'sh8001;
				3: s = 16'($urandom_range(0, 7));
				4: s = -16'($urandom_range(1, 8));
				default: s = 16'($urandom);
			endcase
			if (mute[i % cnt]) s = '0;
			add(s, with_end && (i == len - 1));
		end
	endtask

	initial begin : stimulus
		logic [3:0] sweep [10];
		int unsigned rand_items;
		int unsigned stash;
		int unsigned len;
		int unsigned phase;
		sweep = '{4'd1, 4'd3, 4'd5, 4'd8, 4'd0, 4'd15, 4'd2, 4'd7, 4'd4, 4'd6};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add(16'sh7fff, 1'b0);
		add(16'sh8000, 1'b1);
		add(16'sh0000, 1'b0);
		add(16'sh0000, 1'b1);
		add(16'sh0001, 1'b0);
		add(-16'sh0001, 1'b1);
		add(-16'sh0002, 1'b1);
		quiesce();
		write_count(4'd8);
		add(16'sh8000, 1'b0);
		add(16'sh7fff, 1'b0);
		add(16'sh0000, 1'b0);
		add(16'sh0001, 1'b0);
		add(-16'sh0001, 1'b0);
		add(16'sh4000, 1'b0);
		add(-16'sh4000, 1'b0);
		add(16'sh5555, 1'b1);
		quiesce();
		write_count(4'd1);
		add(-16'sh0003, 1'b1);
		quiesce();
		write_count(4'd0);
		add(16'sh0005, 1'b1);
		quiesce();
		write_count(4'd15);
		add(16'sh0009, 1'b1);
		quiesce();
		write_count(4'd8);
		add(16'sh03e8, 1'b0);
		add(-16'sh07d0, 1'b0);
		add(16'sh0bb8, 1'b0);
		add(-16'sh0fa0, 1'b0);
		quiesce();
		write_count(4'd3);
		add(-16'sh4e20, 1'b1);

		rand_items = 0;
		phase = 0;
		while (rand_items < RANDOM_ITEMS) begin
			quiesce();
			write_count(phase < 10 ? sweep[phase] : 4'($urandom_range(0, 15)));
			send_gaps = ($urandom_range(0, 3) != 0);
			rx_style = rx_style_t'($urandom_range(0, 2));
			if (phase == 3) begin
				send_gaps = 1'b0;
				rx_style = RX_FREE;
				holdoff_go = 1'b1;
			end
			stash = 0;
			while (stash < 38) begin
				if ($urandom_range(0, 4) == 0) len = $urandom_range(1, 20);
				else len = $urandom_range(1, 3) * eff_count();
				queue_frame(len, 1'b1);
				stash += len;
			end
			if ($urandom_range(0, 3) == 0) begin
				len = $urandom_range(1, 9);
				queue_frame(len, 1'b0);
				stash += len;
			end
			rand_items += stash;
			phase++;
		end

		quiesce();
		$display("covered %0d samples in %0d frames, %0d levels checked, %0d count writes",
			n_samples, n_frames, n_levels, n_writes);
		$display("input held back for %0d cycles by the meter", n_held);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule

// File: filelist.f
design/iapm_pkg.sv
design/iapm_ctl.sv
design/iapm_dp.sv
design/interleaved_audio_peak_meter_db.sv
sim/tb.sv
